/* sv/msh_pkg.sv */
// Shared types, constants and codes for the mid-square hash table.
package msh_pkg;

    localparam int SLOT_COUNT_DEF = 10;
    localparam int IDX_W          = 7;
    localparam int KEY_W          = 32;
    localparam int SQ_W           = 63;
    localparam int DIGITS         = 19;
    localparam int BCD_W          = 4 * DIGITS;
    localparam int CNT_W          = 6;
    localparam int DIG_IDX_W      = 5;
    localparam int TWO_W          = 7;
    localparam int TWO_RANGE      = 100;
    localparam int FIFO_DEPTH     = 2;
    localparam int OUT_IDX_W      = 4;

    typedef enum logic {
        OP_INSERT = 1'b0,
        OP_REMOVE = 1'b1
    } t_op;

    typedef enum logic [1:0] {
        ST_INSERTED  = 2'd0,
        ST_COLLISION = 2'd1,
        ST_REMOVED   = 2'd2,
        ST_NOT_FOUND = 2'd3
    } t_status;

    typedef struct packed {
        t_op              op;
        logic [KEY_W-1:0] key;
        logic [IDX_W-1:0] slot;
    } t_job;

    typedef struct packed {
        logic [OUT_IDX_W-1:0] slot_index;
        t_status              status;
    } t_result;

endpackage

/* sv/mid_square_hash_table.sv */
// Top level of the mid-square hash table: front end, job queue, back end, result queue.
//
//  channel   handshake               payload
//  input     push / full             i_op, i_key
//  result    empty / pop             o_slot_index, o_status
//
// In the front end an item goes through capture, square, 63 steps of the
// binary-to-decimal conversion, digit pick and hand-off; that conversion sets the rate.
// The back end reads the slot when it takes an item (B_IDLE) and updates it in B_EXEC.
// Reset clears the job and result queues and marks every slot empty; keys are not cleared.
// full stays high while the front end works on an item; two results queue while pop is low.
module mid_square_hash_table #(
    parameter int SLOT_COUNT = msh_pkg::SLOT_COUNT_DEF
) (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             push,
    output logic                             full,
    input  logic                             i_op,
    input  logic signed [msh_pkg::KEY_W-1:0] i_key,
    output logic                             empty,
    input  logic                             pop,
    output logic [msh_pkg::OUT_IDX_W-1:0]    o_slot_index,
    output logic [1:0]                       o_status
);
    import msh_pkg::*;

    t_job    w_front_job;
    t_job    w_back_job;
    t_result w_back_res;
    t_result w_out_res;
    logic    w_front_valid;
    logic    w_jq_full;
    logic    w_jq_empty;
    logic    w_back_ready;
    logic    w_res_valid;
    logic    w_rq_full;

    msh_front #(
        .SLOT_COUNT(SLOT_COUNT)
    ) u_front (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_push     (push),
        .o_full     (full),
        .i_op       (i_op),
        .i_key      (i_key),
        .o_job_valid(w_front_valid),
        .i_job_ready(!w_jq_full),
        .o_job      (w_front_job)
    );

    msh_fifo #(
        .W($bits(t_job))
    ) u_job_q (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_push (w_front_valid),
        .i_data (w_front_job),
        .o_full (w_jq_full),
        .o_empty(w_jq_empty),
        .i_pop  (w_back_ready),
        .o_data (w_back_job)
    );

    msh_back #(
        .SLOT_COUNT(SLOT_COUNT)
    ) u_back (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_job_valid(!w_jq_empty),
        .o_job_ready(w_back_ready),
        .i_job      (w_back_job),
        .o_res_valid(w_res_valid),
        .i_res_ready(!w_rq_full),
        .o_res      (w_back_res)
    );

    msh_fifo #(
        .W($bits(t_result))
    ) u_res_q (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_push (w_res_valid),
        .i_data (w_back_res),
        .o_full (w_rq_full),
        .o_empty(empty),
        .i_pop  (pop),
        .o_data (w_out_res)
    );

    assign o_slot_index = w_out_res.slot_index;
    assign o_status     = w_out_res.status;

endmodule

/* sv/msh_fifo.sv */
// Short register queue that decouples two stages of the hash table.
module msh_fifo #(
    parameter int W = 8
) (
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  logic         i_push,
    input  logic [W-1:0] i_data,
    output logic         o_full,
    output logic         o_empty,
    input  logic         i_pop,
    output logic [W-1:0] o_data
);
    import msh_pkg::*;

    localparam int PTR_W = (FIFO_DEPTH > 1) ? $clog2(FIFO_DEPTH) : 1;
    localparam int CNT_BITS = $clog2(FIFO_DEPTH + 1);

    logic [W-1:0]        r_mem [0:FIFO_DEPTH-1];
    logic [PTR_W-1:0]    r_wr, n_wr;
    logic [PTR_W-1:0]    r_rd, n_rd;
    logic [CNT_BITS-1:0] r_cnt, n_cnt;
    logic                w_wr_en;
    logic                w_rd_en;

    assign o_full  = (r_cnt == CNT_BITS'(FIFO_DEPTH));
    assign o_empty = (r_cnt == '0);
    assign o_data  = r_mem[r_rd];
    assign w_wr_en = i_push && !o_full;
    assign w_rd_en = i_pop && !o_empty;

    always_comb begin
        n_wr  = r_wr;
        n_rd  = r_rd;
        n_cnt = r_cnt;
        if (w_wr_en) begin
            n_wr = (r_wr == PTR_W'(FIFO_DEPTH - 1)) ? '0 : r_wr + PTR_W'(1);
        end
        if (w_rd_en) begin
            n_rd = (r_rd == PTR_W'(FIFO_DEPTH - 1)) ? '0 : r_rd + PTR_W'(1);
        end
        if (w_wr_en && !w_rd_en) begin
            n_cnt = r_cnt + CNT_BITS'(1);
        end else if (w_rd_en && !w_wr_en) begin
            n_cnt = r_cnt - CNT_BITS'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= '0;
            r_rd  <= '0;
            r_cnt <= '0;
        end else begin
            r_wr  <= n_wr;
            r_rd  <= n_rd;
            r_cnt <= n_cnt;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_wr_en) begin
            r_mem[r_wr] <= i_data;
        end
    end

    a_cnt_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_cnt <= CNT_BITS'(FIFO_DEPTH)) && (r_wr == PTR_W'((r_rd + r_cnt) % FIFO_DEPTH)))
        else $error("queue count and pointers disagree");

endmodule

/* sv/msh_front.sv */
// Front end: accepts items and works out the mid-square slot of each key.
module msh_front #(
    parameter int SLOT_COUNT = msh_pkg::SLOT_COUNT_DEF
) (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      i_push,
    output logic                      o_full,
    input  logic                      i_op,
    input  logic signed [msh_pkg::KEY_W-1:0] i_key,
    output logic                      o_job_valid,
    input  logic                      i_job_ready,
    output msh_pkg::t_job             o_job
);
    import msh_pkg::*;

    localparam int SLOT_W = (SLOT_COUNT > 1) ? $clog2(SLOT_COUNT) : 1;

    typedef enum logic [4:0] {
        F_IDLE = 5'b00001,
        F_SQ   = 5'b00010,
        F_CONV = 5'b00100,
        F_PICK = 5'b01000,
        F_PUSH = 5'b10000
    } t_fstate;

    t_fstate              r_state, n_state;
    t_op                  r_op;
    logic [KEY_W-1:0]     r_key;
    logic [KEY_W-1:0]     r_mag;
    logic [SQ_W-1:0]      r_sq;
    logic [BCD_W-1:0]     r_bcd;
    logic [CNT_W-1:0]     r_cnt;
    logic [TWO_W-1:0]     r_two;

    logic [KEY_W-1:0]     w_key_u;
    logic [2*KEY_W-1:0]   w_prod;
    logic [BCD_W-1:0]     w_adj;
    logic [DIG_IDX_W-1:0] w_top;
    logic [DIG_IDX_W-1:0] w_mid;
    logic [DIG_IDX_W-1:0] w_lo;
    logic [DIG_IDX_W-1:0] w_hi;
    logic [3:0]           w_d_lo;
    logic [3:0]           w_d_hi;
    logic [TWO_W-1:0]     w_two;
    logic [SLOT_W-1:0]    w_mod_tab [0:TWO_RANGE-1];

    for (genvar g = 0; g < TWO_RANGE; g++) begin : g_mod
        assign w_mod_tab[g] = SLOT_W'(g % SLOT_COUNT);
    end

    assign w_key_u = i_key;
    assign w_prod  = r_mag * r_mag;
    assign o_full  = (r_state != F_IDLE);

    always_comb begin
        for (int i = 0; i < DIGITS; i++) begin
            w_adj[4*i +: 4] = (r_bcd[4*i +: 4] >= 4'd5) ? r_bcd[4*i +: 4] + 4'd3
                                                        : r_bcd[4*i +: 4];
        end
    end

    always_comb begin
        w_top = '0;
        for (int i = 1; i < DIGITS; i++) begin
            if (r_bcd[4*i +: 4] != 4'd0) begin
                w_top = DIG_IDX_W'(i);
            end
        end
        w_mid  = DIG_IDX_W'(({1'b0, w_top} + 6'd1) >> 1);
        w_lo   = w_top - w_mid;
        w_hi   = w_lo + DIG_IDX_W'(1);
        w_d_lo = r_bcd[4*w_lo +: 4];
        w_d_hi = r_bcd[4*w_hi +: 4];
        if (w_top == '0) begin
            w_two = {3'b000, r_bcd[3:0]};
        end else begin
            w_two = {3'b000, w_d_hi} * TWO_W'(10) + {3'b000, w_d_lo};
        end
    end

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            F_IDLE: begin
                if (i_push) begin
                    n_state = F_SQ;
                end
            end
            F_SQ: n_state = F_CONV;
            F_CONV: begin
                if (r_cnt == CNT_W'(SQ_W - 1)) begin
                    n_state = F_PICK;
                end
            end
            F_PICK: n_state = F_PUSH;
            F_PUSH: begin
                if (i_job_ready) begin
                    n_state = F_IDLE;
                end
            end
            default: n_state = F_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= F_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_ff @(posedge i_clk) begin
        unique case (r_state)
            F_IDLE: begin
                if (i_push) begin
                    r_op  <= t_op'(i_op);
                    r_key <= w_key_u;
                    r_mag <= i_key[KEY_W-1] ? (~w_key_u + KEY_W'(1)) : w_key_u;
                end
            end
            F_SQ: begin
                r_sq  <= w_prod[SQ_W-1:0];
                r_bcd <= '0;
                r_cnt <= '0;
            end
            F_CONV: begin
                r_bcd <= {w_adj[BCD_W-2:0], r_sq[SQ_W-1]};
                r_sq  <= {r_sq[SQ_W-2:0], 1'b0};
                r_cnt <= r_cnt + CNT_W'(1);
            end
            F_PICK: r_two <= w_two;
            F_PUSH: ;
            default: ;
        endcase
    end

    assign o_job_valid = (r_state == F_PUSH);
    assign o_job.op    = r_op;
    assign o_job.key   = r_key;
    assign o_job.slot  = IDX_W'(w_mod_tab[r_two]);

endmodule

/* sv/msh_back.sv */
// Back end: slot store, insert and remove against the hashed slot.
module msh_back #(
    parameter int SLOT_COUNT = msh_pkg::SLOT_COUNT_DEF
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_job_valid,
    output logic             o_job_ready,
    input  msh_pkg::t_job    i_job,
    output logic             o_res_valid,
    input  logic             i_res_ready,
    output msh_pkg::t_result o_res
);
    import msh_pkg::*;

    localparam int SLOT_W = (SLOT_COUNT > 1) ? $clog2(SLOT_COUNT) : 1;

    typedef enum logic [1:0] {
        B_IDLE = 2'b01,
        B_EXEC = 2'b10
    } t_bstate;

    t_bstate             r_state, n_state;
    logic [KEY_W-1:0]    r_mem [0:SLOT_COUNT-1];
    logic [SLOT_COUNT-1:0] r_used;
    logic [SLOT_COUNT-1:0] r_gone;
    t_op                 r_op;
    logic [KEY_W-1:0]    r_key;
    logic [IDX_W-1:0]    r_slot;
    logic [KEY_W-1:0]    r_rd_key;

    logic [SLOT_W-1:0]   w_in_idx;
    logic [SLOT_W-1:0]   w_idx;
    logic                w_take;
    logic                w_ins_ok;
    logic                w_rem_ok;
    t_status             w_status;

    assign w_in_idx    = i_job.slot[SLOT_W-1:0];
    assign w_idx       = r_slot[SLOT_W-1:0];
    assign o_job_ready = (r_state == B_IDLE) && i_res_ready;
    assign w_take      = o_job_ready && i_job_valid;
    assign w_ins_ok    = (r_op == OP_INSERT) && !r_used[w_idx];
    assign w_rem_ok    = (r_op == OP_REMOVE) && r_used[w_idx] && (r_rd_key == r_key);

    always_comb begin
        priority if (r_op == OP_INSERT) begin
            w_status = w_ins_ok ? ST_INSERTED : ST_COLLISION;
        end else begin
            w_status = w_rem_ok ? ST_REMOVED : ST_NOT_FOUND;
        end
    end

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            B_IDLE: begin
                if (w_take) begin
                    n_state = B_EXEC;
                end
            end
            B_EXEC: n_state = B_IDLE;
            default: n_state = B_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= B_IDLE;
            r_used  <= '0;
            r_gone  <= '0;
        end else begin
            r_state <= n_state;
            if (r_state == B_EXEC) begin
                if (w_ins_ok) begin
                    r_used[w_idx] <= 1'b1;
                    r_gone[w_idx] <= 1'b0;
                end else if (w_rem_ok) begin
                    r_used[w_idx] <= 1'b0;
                    r_gone[w_idx] <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_take) begin
            r_op     <= i_job.op;
            r_key    <= i_job.key;
            r_slot   <= i_job.slot;
            r_rd_key <= r_mem[w_in_idx];
        end
        if ((r_state == B_EXEC) && w_ins_ok) begin
            r_mem[w_idx] <= r_key;
        end
    end

    assign o_res_valid      = (r_state == B_EXEC);
    assign o_res.slot_index = r_slot[OUT_IDX_W-1:0];
    assign o_res.status     = w_status;

    a_mark_excl: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_used & r_gone) == '0)
        else $error("slot both occupied and deleted");

    a_insert_sets: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_res_valid && (w_status == ST_INSERTED)) |=> r_used[$past(w_idx)])
        else $error("insert did not occupy its slot");

    a_remove_clears: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_res_valid && (w_status == ST_REMOVED)) |=>
        (!r_used[$past(w_idx)] && r_gone[$past(w_idx)]))
        else $error("remove did not mark its slot deleted");

endmodule
